// ===== design/twef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time window event FIFO package
// Shared operation and status codes, the sequencer state type and the
// result record passed from the core to the response register.
// ----------------------------------------------------------------------------
package twef_pkg;

   // Fixed field widths of the request and response records.
   localparam int TIME_W      = 64;
   localparam int OFFSET_W    = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_PRUNE  = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_GET    = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // Core sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_GET,
      ST_PRUNE,
      ST_DONE
   } state_type;

   // One finished response.
   typedef struct packed {
      logic [TIME_W-1:0]      read_time;
      logic [COUNT_OUT_W-1:0] held_count;
      logic [STATUS_W-1:0]    status;
   } result_type;

endpackage

// ===== design/twef_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time window event FIFO core
// Ring buffer of timestamps in a synchronous memory, with head and count
// registers and a sequencer that runs one request at a time.
// ----------------------------------------------------------------------------
module twef_core
   import twef_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OP_W-1:0]     in_operation,
   input  logic [TIME_W-1:0]   in_time_stamp,
   input  logic [OFFSET_W-1:0] in_read_offset,
   input  logic [TIME_W-1:0]   window_length,
   input  logic                slot_free,
   output logic                idle,
   output logic                done,
   output result_type          result
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 1;

   // Adds an offset to a ring position, folding once past the end.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [AW-1:0] add);
      logic [AW-1:0] sum;
      sum = AW'(base) + add;
      if (sum >= AW'(CAPACITY)) begin
         sum = sum - AW'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [TIME_W-1:0]          stamp_ff, stamp_in;
   logic [TIME_W-1:0]          res_time_ff, res_time_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;

   logic [TIME_W-1:0]          time_store_ff [CAPACITY];
   logic [TIME_W-1:0]          rd_data_ff;
   logic                       wr_en, rd_en;
   logic [IDX_W-1:0]           wr_addr, rd_addr;

   logic                       count_zero, count_one, full, range_err, expired;
   logic [IDX_W-1:0]           tail_addr, get_addr, next_head;
   logic [TIME_W-1:0]          age;
   logic [CNT_W+OFFSET_W-1:0]  offset_wide, count_wide;
   logic [CNT_W+COUNT_OUT_W-1:0] held_wide;

   // Conditions and ring positions derived from the current state.
   assign count_zero  = (count_ff == '0);
   assign count_one   = (count_ff == CNT_W'(1));
   assign full        = (count_ff >= CNT_W'(CAPACITY));
   assign offset_wide = {{CNT_W{1'b0}}, in_read_offset};
   assign count_wide  = {{OFFSET_W{1'b0}}, count_ff};
   assign range_err   = (offset_wide >= count_wide);
   assign tail_addr   = wrap_add(head_ff, AW'(count_ff));
   assign get_addr    = wrap_add(head_ff, AW'(in_read_offset));
   assign next_head   = wrap_add(head_ff, AW'(1));
   assign age         = stamp_ff - rd_data_ff;
   assign expired     = (age > window_length);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (in_operation)
                  OP_PRUNE: state_in = count_zero ? ST_DONE : ST_PRUNE;
                  OP_GET:   state_in = range_err ? ST_DONE : ST_WAIT_GET;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_WAIT_GET: state_in = ST_DONE;
         ST_PRUNE: begin
            if (!(expired && !count_one)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Pointer updates, memory accesses and result fields.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      res_time_in   = res_time_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_addr;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               stamp_in      = in_time_stamp;
               res_time_in   = '0;
               res_status_in = STAT_OK;
               unique case (in_operation)
                  OP_INSERT: begin
                     if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PRUNE: begin
                     rd_en = !count_zero;
                  end
                  OP_DELETE: begin
                     if (!count_zero) begin
                        head_in  = next_head;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_GET: begin
                     if (range_err) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = get_addr;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WAIT_GET: begin
            res_time_in = rd_data_ff;
         end
         ST_PRUNE: begin
            // Drop the expired head and fetch the following entry, if one remains.
            if (expired) begin
               head_in  = next_head;
               count_in = count_ff - CNT_W'(1);
               rd_en    = !count_one;
               rd_addr  = next_head;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stamp_ff      <= stamp_in;
      res_time_ff   <= res_time_in;
      res_status_ff <= res_status_in;
   end

   // Timestamp memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_store_ff[wr_addr] <= in_time_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= time_store_ff[rd_addr];
      end
   end

   // Handshake with the response register.
   assign held_wide         = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign idle              = (state_ff == ST_IDLE);
   assign done              = (state_ff == ST_DONE) && slot_free;
   assign result.read_time  = res_time_ff;
   assign result.held_count = held_wide[COUNT_OUT_W-1:0];
   assign result.status     = res_status_ff;

endmodule

// ===== design/time_window_event_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time window event FIFO
// Sliding time window of 64-bit timestamps kept in a ring buffer, with
// insert, prune, delete-oldest and get-by-offset requests.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                          | Direction
//   --------+------------------------------------------------+----------
//   req     | req_valid/ready, operation, time_stamp, offset | in
//   rsp     | rsp_valid/ready, read_time, held_count, status | out
//   csr     | csr_valid/ready, window_length                 | in
//
// With the response register free, insert and delete go from idle straight to
// the done state, and get passes through a wait state for the memory read.
// Prune goes straight to done on an empty store; otherwise it drops expired
// head entries one at a time until a head survives or the store is empty,
// as each head compare waits on one read from the single memory read port.
// Reset clears head, count, window length and control state; the memory is
// not cleared, and only held entries are ever read.
// A new request is taken while the previous response still waits in the
// response register; the core stalls only when it finishes a request and
// that register is still occupied.
//
module time_window_event_fifo
   import twef_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [TIME_W-1:0]      req_time_stamp,
   input  logic [OFFSET_W-1:0]    req_read_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TIME_W-1:0]      rsp_read_time,
   output logic [COUNT_OUT_W-1:0] rsp_held_count,
   output logic [STATUS_W-1:0]    rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TIME_W-1:0]      csr_window_length
);

   logic [TIME_W-1:0] window_length_ff, window_length_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   logic              core_idle, core_done, slot_free, req_fire;
   result_type        core_result;

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = core_idle;
   assign csr_ready = 1'b1;

   // Window length register.
   assign window_length_in = csr_valid ? csr_window_length : window_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= '0;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   // Ring buffer core.
   twef_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (req_fire),
      .in_operation   (req_operation),
      .in_time_stamp  (req_time_stamp),
      .in_read_offset (req_read_offset),
      .window_length  (window_length_ff),
      .slot_free      (slot_free),
      .idle           (core_idle),
      .done           (core_done),
      .result         (core_result)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_time  = rsp_data_ff.read_time;
   assign rsp_held_count = rsp_data_ff.held_count;
   assign rsp_status     = rsp_data_ff.status;

   // The core never overwrites a response that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // A request is never taken in the cycle the core finishes one.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !core_done)
      else $error("request accepted while core busy");

   // One request at a time: the core is busy right after an acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("core still ready after accepting a request");

   // An out-of-range get returns a zero time.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_RANGE) |-> (rsp_read_time == '0))
      else $error("range error with nonzero read time");

endmodule
